FILE: hw/rtl/lcd4_pkg.sv
package lcd4_pkg;

  localparam int DISPLAY_DEPTH = 128;
  localparam int GLYPH_DEPTH   = 64;
  localparam int DSP_AW        = $clog2(DISPLAY_DEPTH);
  localparam int CG_AW         = $clog2(GLYPH_DEPTH);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] GLYPH_ZERO = 8'h00;

  localparam logic [7:0] CMD_UNKNOWN  = 8'h00;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [6:0] CMD_HOME_TOP = 7'h01;
  localparam logic [1:0] CMD_CGRAM_TOP = 2'b01;

  typedef enum logic [1:0] {
    OP_STROBE = 2'd0,
    OP_RD_DSP = 2'd1,
    OP_RD_CG  = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic              read_dsp;
    logic              read_cg;
    logic              hit;
    logic [DSP_AW-1:0] address_counter;
    logic              cgram_selected;
    logic              awaiting_high;
    logic              unknown_command;
  } s1_t;

endpackage

FILE: hw/rtl/lcd4_if.sv
interface lcd4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] nibble;
  logic       register_select;
  logic [6:0] address;

  modport source (output valid, output opcode, output nibble, output register_select,
                  output address, input ready);
  modport sink (input valid, input opcode, input nibble, input register_select,
                input address, output ready);
endinterface

interface lcd4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [6:0] address_counter;
  logic       cgram_selected;
  logic       awaiting_high;
  logic       unknown_command;

  modport source (output valid, output read_data, output address_counter,
                  output cgram_selected, output awaiting_high, output unknown_command,
                  input ready);
  modport sink (input valid, input read_data, input address_counter,
                input cgram_selected, input awaiting_high, input unknown_command,
                output ready);
endinterface

FILE: hw/rtl/char_lcd_controller_4bit_top.sv
// Channel | Direction | Word
// in_ch   | sink      | opcode, nibble, register_select, address
// out_ch  | source    | read_data, address_counter, cgram_selected, awaiting_high,
//         |           | unknown_command
//
// One word is taken per cycle while the middle stage is free or advancing; its result is
// offered once it has passed the registered RAM read ports and the output register.
// Reset clears the control state and the per-entry valid bits at once, so no clearing
// pass is needed; the clear command also drops all display valid bits at once.
// A stalled output holds its word; input keeps flowing while the middle stage is free.
module char_lcd_controller_4bit_top (
  input  logic       clk,
  input  logic       rst_n,
  lcd4_in_if.sink    in_ch,
  lcd4_out_if.source out_ch
);
  import lcd4_pkg::*;

  logic [DSP_AW-1:0]        wa_r, wa_nxt;
  logic                     tgt_dsp_r, tgt_dsp_nxt;
  logic                     exp_hi_r, exp_hi_nxt;
  logic [3:0]               held_nib_r, held_nib_nxt;
  logic                     held_rs_r, held_rs_nxt;
  logic [DISPLAY_DEPTH-1:0] dsp_vld_r, dsp_vld_nxt;
  logic [GLYPH_DEPTH-1:0]   cg_vld_r, cg_vld_nxt;

  logic s1_v_r;
  s1_t  s1_r, s1_nxt;

  logic              out_v_r;
  logic [7:0]        rd_data_r, rd_data_nxt;
  logic [DSP_AW-1:0] out_ac_r;
  logic              out_cg_r, out_hi_r, out_unk_r;

  logic       accept, advance;
  logic [7:0] byte_w;
  logic       dsp_we, cg_we;
  logic [7:0] dsp_rdata, cg_rdata;

  assign advance      = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;
  assign byte_w       = {held_nib_r, in_ch.nibble};

  always_comb begin
    wa_nxt       = wa_r;
    tgt_dsp_nxt  = tgt_dsp_r;
    exp_hi_nxt   = exp_hi_r;
    held_nib_nxt = held_nib_r;
    held_rs_nxt  = held_rs_r;
    dsp_vld_nxt  = dsp_vld_r;
    cg_vld_nxt   = cg_vld_r;
    dsp_we       = 1'b0;
    cg_we        = 1'b0;
    s1_nxt       = '0;
    if (accept) begin
      unique case (opcode_t'(in_ch.opcode))
        OP_STROBE: begin
          if (exp_hi_r || (in_ch.register_select != held_rs_r)) begin
            held_nib_nxt = in_ch.nibble;
            held_rs_nxt  = in_ch.register_select;
            exp_hi_nxt   = 1'b0;
          end else begin
            exp_hi_nxt = 1'b1;
            if (in_ch.register_select) begin
              if (tgt_dsp_r) begin
                dsp_we            = 1'b1;
                dsp_vld_nxt[wa_r] = 1'b1;
                wa_nxt            = wa_r + DSP_AW'(1);
              end else begin
                cg_we                         = 1'b1;
                cg_vld_nxt[wa_r[CG_AW-1:0]]   = 1'b1;
                wa_nxt = {{(DSP_AW-CG_AW){1'b0}}, wa_r[CG_AW-1:0] + CG_AW'(1)};
              end
            end else begin
              priority if (byte_w == CMD_UNKNOWN) begin
                s1_nxt.unknown_command = 1'b1;
              end else if (byte_w == CMD_CLEAR) begin
                dsp_vld_nxt = '0;
                wa_nxt      = '0;
                tgt_dsp_nxt = 1'b1;
              end else if (byte_w[7:1] == CMD_HOME_TOP) begin
                wa_nxt      = '0;
                tgt_dsp_nxt = 1'b1;
              end else if (byte_w[7]) begin
                wa_nxt      = byte_w[DSP_AW-1:0];
                tgt_dsp_nxt = 1'b1;
              end else if (byte_w[7:6] == CMD_CGRAM_TOP) begin
                wa_nxt      = {{(DSP_AW-CG_AW){1'b0}}, byte_w[CG_AW-1:0]};
                tgt_dsp_nxt = 1'b0;
              end else begin
                wa_nxt = wa_r;
              end
            end
          end
        end
        OP_RD_DSP: begin
          s1_nxt.read_dsp = 1'b1;
          s1_nxt.hit      = dsp_vld_r[in_ch.address];
        end
        OP_RD_CG: begin
          s1_nxt.read_cg = 1'b1;
          s1_nxt.hit     = cg_vld_r[in_ch.address[CG_AW-1:0]];
        end
        OP_RSVD: begin
          s1_nxt.read_dsp = 1'b0;
        end
        default: begin
          s1_nxt.read_dsp = 1'b0;
        end
      endcase
    end
    s1_nxt.address_counter = wa_nxt;
    s1_nxt.cgram_selected  = !tgt_dsp_nxt;
    s1_nxt.awaiting_high   = exp_hi_nxt;
  end

  lcd4_ram #(.WIDTH(8), .DEPTH(DISPLAY_DEPTH)) u_dsp_ram (
    .clk   (clk),
    .we    (dsp_we),
    .waddr (wa_r),
    .wdata (byte_w),
    .re    (accept),
    .raddr (in_ch.address),
    .rdata (dsp_rdata)
  );

  lcd4_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_cg_ram (
    .clk   (clk),
    .we    (cg_we),
    .waddr (wa_r[CG_AW-1:0]),
    .wdata (byte_w),
    .re    (accept),
    .raddr (in_ch.address[CG_AW-1:0]),
    .rdata (cg_rdata)
  );

  always_comb begin
    if (s1_r.read_dsp) begin
      rd_data_nxt = s1_r.hit ? dsp_rdata : CHAR_SPACE;
    end else if (s1_r.read_cg) begin
      rd_data_nxt = s1_r.hit ? cg_rdata : GLYPH_ZERO;
    end else begin
      rd_data_nxt = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_r       <= '0;
      tgt_dsp_r  <= 1'b1;
      exp_hi_r   <= 1'b1;
      held_nib_r <= '0;
      held_rs_r  <= 1'b0;
      dsp_vld_r  <= '0;
      cg_vld_r   <= '0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      wa_r       <= wa_nxt;
      tgt_dsp_r  <= tgt_dsp_nxt;
      exp_hi_r   <= exp_hi_nxt;
      held_nib_r <= held_nib_nxt;
      held_rs_r  <= held_rs_nxt;
      dsp_vld_r  <= dsp_vld_nxt;
      cg_vld_r   <= cg_vld_nxt;
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (advance && s1_v_r) begin
      rd_data_r <= rd_data_nxt;
      out_ac_r  <= s1_r.address_counter;
      out_cg_r  <= s1_r.cgram_selected;
      out_hi_r  <= s1_r.awaiting_high;
      out_unk_r <= s1_r.unknown_command;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.read_data       = rd_data_r;
  assign out_ch.address_counter = out_ac_r;
  assign out_ch.cgram_selected  = out_cg_r;
  assign out_ch.awaiting_high   = out_hi_r;
  assign out_ch.unknown_command = out_unk_r;

  a_unknown_ends_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.unknown_command |-> out_ch.awaiting_high)
    else $error("unknown command reported in the middle of a nibble pair");

  a_cg_address_range: assert property (@(posedge clk) disable iff (!rst_n)
    !tgt_dsp_r |-> (wa_r[DSP_AW-1:CG_AW] == '0))
    else $error("write address beyond glyph RAM while glyph RAM is selected");

  a_mid_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !advance |=> s1_v_r && $stable(s1_r))
    else $error("middle stage word lost or changed while the output stalled");

endmodule

FILE: hw/rtl/lcd4_ram.sv
module lcd4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
